[rtl/pfe_pkg.sv]
package pfe_pkg;

  localparam int unsigned STACK_DEPTH  = 32;
  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned RESULT_WIDTH = 32;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  localparam int unsigned FLG_INVALID = 0;
  localparam int unsigned FLG_UNDER   = 1;
  localparam int unsigned FLG_OVER    = 2;
  localparam int unsigned FLG_DIVZ    = 3;
  localparam int unsigned FLG_COUNT   = 4;

  typedef struct packed {
    logic load;
    logic pop;
    logic take_r;
    logic take_l;
    logic push_digit;
    logic push_alu;
    logic start_unit;
    logic push_unit;
    logic set_invalid;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic is_addsub;
    logic is_div;
    logic is_invalid;
    logic last;
    logic aborted;
    logic r_zero;
    logic unit_done;
    logic out_free;
  } status_t;

  function automatic logic is_digit_char(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

endpackage

[rtl/pfe_muldiv.sv]
module pfe_muldiv #(
  parameter int unsigned W = pfe_pkg::VALUE_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         is_div_i,
  input  logic [W-1:0] lhs_i,
  input  logic [W-1:0] rhs_i,
  output logic         done_o,
  output logic [W-1:0] result_o
);

  localparam int unsigned CNW = $clog2(W + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic           div_q, div_d;
  logic           neg_q, neg_d;
  logic [W-1:0]   acc_q, acc_d;
  logic [W-1:0]   quo_q, quo_d;
  logic [W-1:0]   den_q, den_d;

  logic [W-1:0] lhs_mag, rhs_mag;
  logic [W:0]   rem_sh, trial;

  assign lhs_mag = lhs_i[W-1] ? (~lhs_i + W'(1)) : lhs_i;
  assign rhs_mag = rhs_i[W-1] ? (~rhs_i + W'(1)) : rhs_i;
  assign rem_sh  = {acc_q, quo_q[W-1]};
  assign trial   = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNW'(W);
      div_d  = is_div_i;
      neg_d  = lhs_i[W-1] ^ rhs_i[W-1];
      acc_d  = '0;
      quo_d  = is_div_i ? lhs_mag : lhs_i;
      den_d  = is_div_i ? rhs_mag : rhs_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (div_q) begin
        if (!trial[W]) begin
          acc_d = trial[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[W-1:0];
          quo_d = {quo_q[W-2:0], 1'b0};
        end
      end else begin
        if (quo_q[0]) begin
          acc_d = acc_q + den_q;
        end
        den_d = {den_q[W-2:0], 1'b0};
        quo_d = {1'b0, quo_q[W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~quo_q + W'(1)) : quo_q) : acc_q;

endmodule

[rtl/pfe_dpath.sv]
module pfe_dpath #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pfe_pkg::VALUE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfe_pkg::cmd_t                       cmd_i,
  output pfe_pkg::status_t                    status_o,
  input  logic [7:0]                          character_i,
  input  logic                                end_of_expression_i,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic signed [pfe_pkg::RESULT_WIDTH-1:0] result_value_o,
  output logic                                invalid_character_o,
  output logic                                stack_underflow_o,
  output logic                                stack_overflow_o,
  output logic                                divide_by_zero_o
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned RW  = pfe_pkg::RESULT_WIDTH;
  localparam int unsigned IW  = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned FW  = pfe_pkg::FLG_COUNT;

  logic [W-1:0] stack_mem [STACK_DEPTH];

  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] flags_q, flags_d;
  logic          aborted_q, aborted_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    char_q;
  logic          last_q;
  logic [W-1:0]  rd_q;
  logic          empty_q;
  logic [W-1:0]  opr_q;
  logic [W-1:0]  opl_q;
  logic [RW-1:0] out_value_q;
  logic [FW-1:0] out_flags_q;

  logic [CW-1:0] count_m1;
  logic [IW-1:0] rd_idx, wr_idx;
  logic          push_en, mem_we;
  logic [W-1:0]  push_val, alu_val, unit_val, popped;
  logic [RW-1:0] final_val;
  logic          is_add, is_sub, is_mul, is_div, is_digit;
  logic          unit_done;

  assign is_digit = pfe_pkg::is_digit_char(char_q);
  assign is_add   = (char_q == pfe_pkg::CHAR_PLUS);
  assign is_sub   = (char_q == pfe_pkg::CHAR_MINUS);
  assign is_mul   = (char_q == pfe_pkg::CHAR_STAR);
  assign is_div   = (char_q == pfe_pkg::CHAR_SLASH);

  assign count_m1 = count_q - CW'(1);
  assign rd_idx   = count_m1[IW-1:0];
  assign wr_idx   = count_q[IW-1:0];
  assign popped   = empty_q ? '1 : rd_q;

  always_comb begin
    priority if (is_add) begin
      alu_val = opl_q + opr_q;
    end else if (is_sub) begin
      alu_val = opl_q - opr_q;
    end else begin
      alu_val = '0;
    end
  end

  pfe_muldiv #(
    .W(W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_unit),
    .is_div_i(is_div),
    .lhs_i   (opl_q),
    .rhs_i   (opr_q),
    .done_o  (unit_done),
    .result_o(unit_val)
  );

  assign push_en = cmd_i.push_digit | cmd_i.push_alu | cmd_i.push_unit;

  always_comb begin
    priority if (cmd_i.push_digit) begin
      push_val = {{(W-4){1'b0}}, char_q[3:0]};
    end else if (cmd_i.push_unit) begin
      push_val = unit_val;
    end else begin
      push_val = alu_val;
    end
  end

  always_comb begin
    count_d   = count_q;
    flags_d   = flags_q;
    aborted_d = aborted_q;
    mem_we    = 1'b0;
    if (cmd_i.pop) begin
      if (count_q == '0) begin
        flags_d[pfe_pkg::FLG_UNDER] = 1'b1;
      end else begin
        count_d = count_m1;
      end
    end
    if (push_en) begin
      if (count_q == CW'(STACK_DEPTH)) begin
        flags_d[pfe_pkg::FLG_OVER] = 1'b1;
      end else begin
        mem_we  = 1'b1;
        count_d = count_q + CW'(1);
      end
    end
    if (cmd_i.push_alu && is_div) begin
      flags_d[pfe_pkg::FLG_DIVZ] = 1'b1;
    end
    if (cmd_i.set_invalid) begin
      flags_d[pfe_pkg::FLG_INVALID] = 1'b1;
      aborted_d = 1'b1;
    end
    if (cmd_i.emit) begin
      count_d   = '0;
      flags_d   = '0;
      aborted_d = 1'b0;
    end
  end

  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  if (W >= RW) begin : g_trunc
    assign final_val = opr_q[RW-1:0];
  end else begin : g_sext
    assign final_val = {{(RW-W){opr_q[W-1]}}, opr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      flags_q     <= '0;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      flags_q     <= flags_d;
      aborted_q   <= aborted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_idx] <= push_val;
    end
    if (cmd_i.pop) begin
      rd_q    <= stack_mem[rd_idx];
      empty_q <= (count_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      char_q <= character_i;
      last_q <= end_of_expression_i;
    end
    if (cmd_i.take_r) begin
      opr_q <= popped;
    end
    if (cmd_i.take_l) begin
      opl_q <= popped;
    end
    if (cmd_i.emit) begin
      out_value_q <= aborted_q ? '1 : final_val;
      out_flags_q <= flags_q;
    end
  end

  assign status_o.is_digit   = is_digit;
  assign status_o.is_addsub  = is_add | is_sub;
  assign status_o.is_div     = is_div;
  assign status_o.is_invalid = ~(is_digit | is_add | is_sub | is_mul | is_div);
  assign status_o.last       = last_q;
  assign status_o.aborted    = aborted_q;
  assign status_o.r_zero     = (opr_q == '0);
  assign status_o.unit_done  = unit_done;
  assign status_o.out_free   = ~out_valid_q | ~out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign result_value_o      = out_value_q;
  assign invalid_character_o = out_flags_q[pfe_pkg::FLG_INVALID];
  assign stack_underflow_o   = out_flags_q[pfe_pkg::FLG_UNDER];
  assign stack_overflow_o    = out_flags_q[pfe_pkg::FLG_OVER];
  assign divide_by_zero_o    = out_flags_q[pfe_pkg::FLG_DIVZ];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result beat overwritten while stalled");

  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0 && flags_q == '0 && !aborted_q && out_valid_q))
    else $error("expression state not cleared on emit");
`endif

endmodule

[rtl/pfe_ctrl.sv]
module pfe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pfe_pkg::status_t status_i,
  output pfe_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POPL,
    S_TAKEL,
    S_EXEC,
    S_WAIT,
    S_FPOP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   ftake_q, ftake_d;

  always_comb begin
    state_d = state_q;
    ftake_d = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status_i.aborted) begin
          state_d = status_i.last ? S_EMIT : S_IDLE;
        end else if (status_i.is_digit) begin
          cmd_o.push_digit = 1'b1;
          state_d          = status_i.last ? S_FPOP : S_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_POPL;
        end
      end
      S_POPL: begin
        cmd_o.take_r = 1'b1;
        cmd_o.pop    = 1'b1;
        state_d      = S_TAKEL;
      end
      S_TAKEL: begin
        cmd_o.take_l = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        priority if (status_i.is_invalid) begin
          cmd_o.set_invalid = 1'b1;
          state_d           = status_i.last ? S_EMIT : S_IDLE;
        end else if (status_i.is_addsub || (status_i.is_div && status_i.r_zero)) begin
          cmd_o.push_alu = 1'b1;
          state_d        = status_i.last ? S_FPOP : S_IDLE;
        end else begin
          cmd_o.start_unit = 1'b1;
          state_d          = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status_i.unit_done) begin
          cmd_o.push_unit = 1'b1;
          state_d         = status_i.last ? S_FPOP : S_IDLE;
        end
      end
      S_FPOP: begin
        cmd_o.pop = 1'b1;
        ftake_d   = 1'b1;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (ftake_q) begin
          cmd_o.take_r = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ftake_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ftake_q <= ftake_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/postfix_expression_evaluator.sv]
// Each input beat is decoded in turn: a digit is pushed, + and - pop two operands and
// push the sum or difference, and * and / run on the one-bit-per-cycle multiply/divide
// unit. An end mark adds the final pop and emit (emit only once aborted), which waits
// on any output stall; in_stall_o holds off the next character until then.
// Reset: asynchronous, active low; clears stack count, flags, abort state and the
// output beat; stack contents are not cleared and no clearing pass is run.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = pfe_pkg::STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = pfe_pkg::VALUE_WIDTH
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic [7:0]                              character_i,
  input  logic                                    end_of_expression_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pfe_pkg::RESULT_WIDTH-1:0] result_value_o,
  output logic                                    invalid_character_o,
  output logic                                    stack_underflow_o,
  output logic                                    stack_overflow_o,
  output logic                                    divide_by_zero_o
);

  pfe_pkg::cmd_t    cmd;
  pfe_pkg::status_t status;

  pfe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pfe_dpath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .character_i        (character_i),
    .end_of_expression_i(end_of_expression_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .result_value_o     (result_value_o),
    .invalid_character_o(invalid_character_o),
    .stack_underflow_o  (stack_underflow_o),
    .stack_overflow_o   (stack_overflow_o),
    .divide_by_zero_o   (divide_by_zero_o)
  );

endmodule

[tb/postfix_expression_evaluator_test.sv]
`timescale 1ns / 1ps

module postfix_expression_evaluator_test;

  localparam int unsigned ITEM_TARGET = 1700;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned VW = pfe_pkg::VALUE_WIDTH;
  localparam int unsigned SD = pfe_pkg::STACK_DEPTH;
  localparam int unsigned RW = pfe_pkg::RESULT_WIDTH;

  typedef struct packed {
    logic [RW-1:0] value;
    logic          inv;
    logic          under;
    logic          over;
    logic          divz;
  } result_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoe;
    logic       typed;
    result_t    want;
  } beat_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           character_i;
  logic                 end_of_expression_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [RW-1:0] result_value_o;
  logic                 invalid_character_o;
  logic                 stack_underflow_o;
  logic                 stack_overflow_o;
  logic                 divide_by_zero_o;

  postfix_expression_evaluator u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .character_i         (character_i),
    .end_of_expression_i (end_of_expression_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .result_value_o      (result_value_o),
    .invalid_character_o (invalid_character_o),
    .stack_underflow_o   (stack_underflow_o),
    .stack_overflow_o    (stack_overflow_o),
    .divide_by_zero_o    (divide_by_zero_o)
  );

  // operand stack mirror
  logic [VW-1:0]                 stk_mem [SD];
  int unsigned                   stk_depth = 0;
  logic [pfe_pkg::FLG_COUNT-1:0] err_flags = '0;
  logic                          expr_aborted = 1'b0;

  result_t     pending_results [$];
  logic [7:0]  expr_chars [$];
  result_t     mon_want;
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned results_checked = 0;
  int unsigned seen_inv = 0;
  int unsigned seen_under = 0;
  int unsigned seen_over = 0;
  int unsigned seen_divz = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_stall_pct = 75;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned cycle_count = 0;

  function automatic void stk_push(input logic [VW-1:0] v);
    if (stk_depth >= SD) begin
      err_flags[pfe_pkg::FLG_OVER] = 1'b1;
    end else begin
      stk_mem[stk_depth] = v;
      stk_depth++;
    end
  endfunction

  function automatic logic [VW-1:0] stk_pop();
    if (stk_depth == 0) begin
      err_flags[pfe_pkg::FLG_UNDER] = 1'b1;
      return '1;
    end
    stk_depth--;
    return stk_mem[stk_depth];
  endfunction

  function automatic logic rpn_step(input logic [7:0] ch, input logic last,
                                    output result_t res);
    logic [VW-1:0] rhs;
    logic [VW-1:0] lhs;
    res = '0;
    if (!expr_aborted) begin
      if (ch >= pfe_pkg::CHAR_ZERO && ch <= pfe_pkg::CHAR_NINE) begin
        stk_push(VW'(ch - pfe_pkg::CHAR_ZERO));
      end else begin
        rhs = stk_pop();
        lhs = stk_pop();
        case (ch)
          pfe_pkg::CHAR_PLUS:  stk_push(lhs + rhs);
          pfe_pkg::CHAR_MINUS: stk_push(lhs - rhs);
          pfe_pkg::CHAR_STAR:  stk_push(lhs * rhs);
          pfe_pkg::CHAR_SLASH: begin
            if (rhs == '0) begin
              err_flags[pfe_pkg::FLG_DIVZ] = 1'b1;
              stk_push('0);
            end else if (lhs == {1'b1, {(VW-1){1'b0}}} && rhs == '1) begin
              stk_push(lhs);
            end else begin
              stk_push($signed(lhs) / $signed(rhs));
            end
          end
          default: begin
            err_flags[pfe_pkg::FLG_INVALID] = 1'b1;
            expr_aborted = 1'b1;
          end
        endcase
      end
    end
    if (!last) return 1'b0;
    res.value = expr_aborted ? '1 : stk_pop();
    res.inv   = err_flags[pfe_pkg::FLG_INVALID];
    res.under = err_flags[pfe_pkg::FLG_UNDER];
    res.over  = err_flags[pfe_pkg::FLG_OVER];
    res.divz  = err_flags[pfe_pkg::FLG_DIVZ];
    stk_depth = 0;
    err_flags = '0;
    expr_aborted = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0: return pfe_pkg::CHAR_PLUS;
      1: return pfe_pkg::CHAR_MINUS;
      2: return pfe_pkg::CHAR_STAR;
      default: return pfe_pkg::CHAR_SLASH;
    endcase
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
               $time, field, $signed(want), want, $signed(got), got);
      mismatches++;
    end
  endfunction

  // hold each beat until accepted, then advance at the next falling edge
  task automatic send_beat(input beat_t b);
    result_t res;
    logic    has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    character_i <= b.ch;
    end_of_expression_i <= b.eoe;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_res = rpn_step(b.ch, b.eoe, res);
    if (has_res) pending_results.push_back(b.typed ? b.want : res);
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_expr();
    foreach (expr_chars[k]) begin
      send_beat({expr_chars[k], k == expr_chars.size() - 1, 1'b0, 36'd0});
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got %0d", $time, result_value_o);
        mismatches++;
      end else begin
        mon_want = pending_results.pop_front();
        check_field("result_value", mon_want.value, result_value_o);
        check_field("invalid_character", 32'(mon_want.inv), 32'(invalid_character_o));
        check_field("stack_underflow", 32'(mon_want.under), 32'(stack_underflow_o));
        check_field("stack_overflow", 32'(mon_want.over), 32'(stack_overflow_o));
        check_field("divide_by_zero", 32'(mon_want.divz), 32'(divide_by_zero_o));
        results_checked++;
        seen_inv += 32'(mon_want.inv);
        seen_under += 32'(mon_want.under);
        seen_over += 32'(mon_want.over);
        seen_divz += 32'(mon_want.divz);
      end
    end
  end

  initial begin
    beat_t       dir_rows [$];
    int unsigned phase;
    int unsigned kind;
    int unsigned n_ops;
    int unsigned digits_left;
    int unsigned depth;
    logic [7:0]  c;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    character_i = '0;
    end_of_expression_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    dir_rows.push_back({pfe_pkg::CHAR_NINE, 1'b1, 1'b1, 32'd9, 4'b0000});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO, 1'b1, 1'b1, 32'd0, 4'b0000});
    dir_rows.push_back({8'hff, 1'b1, 1'b1, 32'hffff_ffff, 4'b1100});
    dir_rows.push_back({8'h00, 1'b1, 1'b1, 32'hffff_ffff, 4'b1100});
    dir_rows.push_back({pfe_pkg::CHAR_PLUS, 1'b1, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_NINE, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_SLASH, 1'b1, 1'b1, 32'd0, 4'b0001});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd5, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd3, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_MINUS, 1'b1, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_NINE, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_NINE, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_STAR, 1'b1, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd3, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd8, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_MINUS, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd2, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_SLASH, 1'b1, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd7, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({8'h2e, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd4, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_PLUS, 1'b1, 1'b1, 32'hffff_ffff, 4'b1100});
    dir_rows.push_back({pfe_pkg::CHAR_ZERO + 8'd8, 1'b0, 1'b0, 36'd0});
    dir_rows.push_back({pfe_pkg::CHAR_MINUS, 1'b1, 1'b0, 36'd0});
    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // most negative value divided by minus one
    expr_chars.delete();
    expr_chars.push_back(pfe_pkg::CHAR_ZERO + 8'd2);
    repeat (VW - 2) begin
      expr_chars.push_back(pfe_pkg::CHAR_ZERO + 8'd2);
      expr_chars.push_back(pfe_pkg::CHAR_STAR);
    end
    expr_chars.push_back(pfe_pkg::CHAR_ZERO);
    expr_chars.push_back(pfe_pkg::CHAR_ZERO + 8'd1);
    expr_chars.push_back(pfe_pkg::CHAR_MINUS);
    expr_chars.push_back(pfe_pkg::CHAR_SLASH);
    send_expr();

    // fill the stack past its depth
    expr_chars.delete();
    repeat (SD + 2) expr_chars.push_back(pfe_pkg::CHAR_NINE);
    expr_chars.push_back(pfe_pkg::CHAR_STAR);
    send_expr();

    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      if (phase == 0 && beats_sent >= ITEM_TARGET / 3) begin
        drain_results();
        phase = 1;
        send_idle_pct = 75;
        recv_stall_pct = 35;
      end else if (phase == 1 && beats_sent >= 2 * ITEM_TARGET / 3) begin
        drain_results();
        phase = 2;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
      end

      kind = $urandom_range(99);
      expr_chars.delete();
      if (kind >= 85) begin
        send_beat({8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 36'd0});
      end else if (kind >= 81) begin
        repeat ($urandom_range(SD - 2, SD + 8)) begin
          expr_chars.push_back(pfe_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
        repeat ($urandom_range(3)) expr_chars.push_back(pick_operator());
        send_expr();
      end else begin
        n_ops = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(4);
        digits_left = n_ops + 1;
        depth = 0;
        while (digits_left > 0 || depth > 1) begin
          if (depth >= 2 && (digits_left == 0 || $urandom_range(1) == 1)) begin
            expr_chars.push_back(pick_operator());
            depth--;
          end else begin
            expr_chars.push_back(pfe_pkg::CHAR_ZERO + 8'($urandom_range(9)));
            depth++;
            digits_left--;
          end
        end
        if (kind >= 70) begin
          case ($urandom_range(3))
            0: begin
              do c = 8'($urandom_range(255));
              while ((c >= pfe_pkg::CHAR_ZERO && c <= pfe_pkg::CHAR_NINE) ||
                     c == pfe_pkg::CHAR_PLUS || c == pfe_pkg::CHAR_MINUS ||
                     c == pfe_pkg::CHAR_STAR || c == pfe_pkg::CHAR_SLASH);
              expr_chars.insert($urandom_range(expr_chars.size()), c);
            end
            1: expr_chars.push_back(pick_operator());
            2: if (expr_chars.size() > 1) expr_chars.delete(expr_chars.size() - 1);
            default: expr_chars.insert($urandom_range(expr_chars.size()),
                                       pfe_pkg::CHAR_ZERO + 8'($urandom_range(9)));
          endcase
        end
        send_expr();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d characters and checked %0d results over three idle profiles.",
             beats_sent, results_checked);
    $display("Flagged results: invalid %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             seen_inv, seen_under, seen_over, seen_divz);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
